// ===== design/face_neighbour_morton_keys_assert.svh =====
// Assertion macros for the face neighbour key block.
`ifndef FACE_NEIGHBOUR_MORTON_KEYS_ASSERT_SVH
`define FACE_NEIGHBOUR_MORTON_KEYS_ASSERT_SVH
`ifndef SYNTHESIS
`define FNMK_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fnmk same-cycle check failed");
`define FNMK_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fnmk next-cycle check failed");
`else
`define FNMK_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define FNMK_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/fnmk_pkg.sv =====
`default_nettype none

package fnmk_pkg;

  localparam int unsigned ANCHOR_W  = 20;
  localparam int unsigned COORD_W   = 21;
  localparam int unsigned LEVEL_W   = 5;
  localparam int unsigned FACE_W    = 3;
  localparam int unsigned KEY_W     = 63;
  localparam int unsigned GAP_W     = 2;
  localparam int unsigned SHIFT_W   = 5;
  // In-block tangential index: supports gaps up to three.
  localparam int unsigned TW        = 3;
  localparam int unsigned DEEPEST_LVL = 20;

  localparam logic [LEVEL_W-1:0] MAX_DEPTH_RST = LEVEL_W'(20);

  localparam logic [FACE_W-1:0] FACE_NX = 3'd0;
  localparam logic [FACE_W-1:0] FACE_PX = 3'd1;
  localparam logic [FACE_W-1:0] FACE_NY = 3'd2;
  localparam logic [FACE_W-1:0] FACE_PY = 3'd3;
  localparam logic [FACE_W-1:0] FACE_NZ = 3'd4;
  localparam logic [FACE_W-1:0] FACE_PZ = 3'd5;

  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    JOB_KEYS,
    JOB_EMPTY,
    JOB_ERROR
  } job_kind_t;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_t;

  // One classified request: the grid of keys is up to four aligned blocks,
  // block A at corners ua/va, block B one cell size further on.
  typedef struct packed {
    job_kind_t            kind;
    axis_t                axis;
    logic [COORD_W-1:0]   cn;
    logic [COORD_W-1:0]   ua;
    logic [COORD_W-1:0]   ub;
    logic [COORD_W-1:0]   va;
    logic [COORD_W-1:0]   vb;
    logic [SHIFT_W-1:0]   k;
    logic [GAP_W-1:0]     g;
    logic [TW-1:0]        off_u;
    logic [TW-1:0]        off_v;
    logic                 v_major;
    logic                 swap_u;
    logic                 swap_v;
    logic [3:0]           blk_mask;
  } job_t;

  // Block j in key order -> {sel_v, sel_u}, 0 selects block A.
  function automatic logic [1:0] blk_sel(input logic [1:0] j, input logic v_major,
                                         input logic swap_u, input logic swap_v);
    logic su;
    logic sv;
    su = (v_major ? j[0] : j[1]) ^ swap_u;
    sv = (v_major ? j[1] : j[0]) ^ swap_v;
    return {sv, su};
  endfunction

  function automatic logic [KEY_W-1:0] interleave3(input logic [COORD_W-1:0] x,
                                                   input logic [COORD_W-1:0] y,
                                                   input logic [COORD_W-1:0] z);
    logic [KEY_W-1:0] key;
    key = '0;
    for (int b = 0; b < COORD_W; b++) begin
      key[3*b]     = x[b];
      key[3*b + 1] = y[b];
      key[3*b + 2] = z[b];
    end
    return key;
  endfunction

endpackage

`default_nettype wire

// ===== design/fnmk_ifs.sv =====
`default_nettype none

interface fnmk_in_if import fnmk_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ANCHOR_W-1:0] anchor_x;
  logic [ANCHOR_W-1:0] anchor_y;
  logic [ANCHOR_W-1:0] anchor_z;
  logic [LEVEL_W-1:0]  cell_level;
  logic [FACE_W-1:0]   face;
  logic                on_boundary;
  logic                not_balanced;

  modport source(output valid, anchor_x, anchor_y, anchor_z, cell_level, face,
                 on_boundary, not_balanced, input ready);
  modport sink(input valid, anchor_x, anchor_y, anchor_z, cell_level, face,
               on_boundary, not_balanced, output ready);
endinterface

interface fnmk_out_if import fnmk_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] morton_key;
  logic             last;
  logic             empty_res;
  logic             gap_error;

  modport source(output valid, morton_key, last, empty_res, gap_error, input ready);
  modport sink(input valid, morton_key, last, empty_res, gap_error, output ready);
endinterface

`default_nettype wire

// ===== design/face_neighbour_morton_keys.sv =====
// Face neighbour key generator.
// Requests enter on in_if (valid/ready); each names an octant anchor, level,
// face, boundary flag and mode. Results leave on out_if, up to one key per
// cycle while out_if is not stalled; last marks the final result of a request.
// The single register max_depth is written through cfg_valid/cfg_max_depth
// and is always ready. With the enumerator idle, the first result reaches
// out_if through the hold register, job queue, enumerator and output register;
// an unbalanced scan may open on empty positions first.
// The enumerator emits at most one key a cycle, none while out_if stalls:
// balanced requests give four keys (one at the deepest level); boundary,
// empty and error requests give one flagged result; unbalanced requests give
// 4^g keys, scanning up to four 2^g x 2^g blocks of candidates.
// The front classifies the next request while the back still emits keys;
// a two-entry job queue sits between them.
// Reset (rst_n low, synchronous) empties the pipeline and sets max_depth
// to 20. When out_if.ready is low the output register holds its result,
// the enumerator stalls, and in_if.ready drops once the queue fills.
`default_nettype none

module face_neighbour_morton_keys import fnmk_pkg::*; #(
  parameter int unsigned MAX_GAP = 3
) (
  input  logic               clk,
  input  logic               rst_n,
  fnmk_in_if.sink            in_if,
  fnmk_out_if.source         out_if,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [LEVEL_W-1:0] cfg_max_depth
);

  // front -> queue
  logic push;
  job_t push_job;
  logic push_ready;
  // queue -> back
  logic q_valid;
  job_t q_job;
  logic q_pop;

  // Classify requests and hold max_depth.
  fnmk_front #(
    .MAX_GAP(MAX_GAP)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_if        (in_if),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_max_depth(cfg_max_depth),
    .push         (push),
    .push_job     (push_job),
    .q_ready      (push_ready)
  );

  // Decouple classification from key emission.
  fnmk_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .push_ready(push_ready),
    .pop_valid (q_valid),
    .pop_job   (q_job),
    .pop       (q_pop)
  );

  // Enumerate keys in ascending order and drive the result channel.
  fnmk_back #(
    .MAX_GAP(MAX_GAP)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_valid(q_valid),
    .q_job  (q_job),
    .q_pop  (q_pop),
    .out_if (out_if)
  );

endmodule

`default_nettype wire

// ===== design/fnmk_front.sv =====
`default_nettype none

module fnmk_front import fnmk_pkg::*; #(
  parameter int unsigned MAX_GAP = 3
) (
  input  logic               clk,
  input  logic               rst_n,
  fnmk_in_if.sink            in_if,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [LEVEL_W-1:0] cfg_max_depth,
  output logic               push,
  output job_t               push_job,
  input  logic               q_ready
);

  logic [LEVEL_W-1:0]  md_r;
  logic                h_vld_r;
  logic                h_vld_nxt;
  logic [ANCHOR_W-1:0] h_ax_r;
  logic [ANCHOR_W-1:0] h_ay_r;
  logic [ANCHOR_W-1:0] h_az_r;
  logic [LEVEL_W-1:0]  h_lvl_r;
  logic [FACE_W-1:0]   h_face_r;
  logic                h_bnd_r;
  logic                h_nb_r;

  logic                accept;
  logic [LEVEL_W-1:0]  lvl_s;
  logic [LEVEL_W-1:0]  md_s;
  logic [LEVEL_W-1:0]  se;
  logic [LEVEL_W-1:0]  gap5;
  logic [COORD_W:0]    size22;
  logic [COORD_W:0]    dh22;
  logic [COORD_W-1:0]  size_c;
  logic [COORD_W-1:0]  dh;
  logic [COORD_W-1:0]  smask;
  logic [COORD_W-1:0]  dmask;
  logic [TW-1:0]       gmask;
  logic [COORD_W-1:0]  c_n;
  logic [COORD_W-1:0]  c_u;
  logic [COORD_W-1:0]  c_v;
  logic [1:0]          sel;
  job_t                job;

  assign cfg_ready   = 1'b1;
  assign accept      = in_if.valid && in_if.ready;
  assign in_if.ready = !h_vld_r || q_ready;
  assign push        = h_vld_r;
  assign push_job    = job;

  always_comb begin
    h_vld_nxt = h_vld_r;
    if (accept) begin
      h_vld_nxt = 1'b1;
    end else if (q_ready) begin
      h_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      md_r    <= MAX_DEPTH_RST;
      h_vld_r <= 1'b0;
    end else begin
      h_vld_r <= h_vld_nxt;
      if (cfg_valid) begin
        md_r <= cfg_max_depth;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      h_ax_r   <= in_if.anchor_x;
      h_ay_r   <= in_if.anchor_y;
      h_az_r   <= in_if.anchor_z;
      h_lvl_r  <= in_if.cell_level;
      h_face_r <= in_if.face;
      h_bnd_r  <= in_if.on_boundary;
      h_nb_r   <= in_if.not_balanced;
    end
  end

  // Classify the held request and build the enumeration job.
  always_comb begin
    lvl_s = (h_lvl_r > LEVEL_W'(DEEPEST_LVL)) ? LEVEL_W'(DEEPEST_LVL) : h_lvl_r;
    md_s  = (md_r > LEVEL_W'(DEEPEST_LVL)) ? LEVEL_W'(DEEPEST_LVL) : md_r;
    se    = LEVEL_W'(DEEPEST_LVL) - lvl_s;
    gap5  = md_s - lvl_s;

    job          = '0;
    job.kind     = JOB_KEYS;
    job.blk_mask = 4'b0001;

    case (h_face_r)
      FACE_NX, FACE_PX: job.axis = AXIS_X;
      FACE_NY, FACE_PY: job.axis = AXIS_Y;
      default:          job.axis = AXIS_Z;
    endcase

    if (h_bnd_r || (h_face_r > FACE_PZ)) begin
      job.kind = JOB_EMPTY;
    end else if (!h_nb_r) begin
      if (lvl_s < LEVEL_W'(DEEPEST_LVL)) begin
        job.k = SHIFT_W'(se - LEVEL_W'(1));
        job.g = GAP_W'(1);
      end else begin
        job.k = SHIFT_W'(se);
        job.g = '0;
      end
    end else if (md_s < lvl_s) begin
      job.kind = JOB_EMPTY;
    end else if (gap5 > LEVEL_W'(MAX_GAP)) begin
      job.kind = JOB_ERROR;
    end else begin
      job.k = SHIFT_W'(LEVEL_W'(DEEPEST_LVL) - md_s);
      job.g = gap5[GAP_W-1:0];
    end

    size22 = (COORD_W+1)'(1) << se;
    dh22   = (COORD_W+1)'(1) << job.k;
    size_c = size22[COORD_W-1:0];
    dh     = dh22[COORD_W-1:0];
    smask  = COORD_W'(size22 - (COORD_W+1)'(1));
    dmask  = COORD_W'(dh22 - (COORD_W+1)'(1));
    gmask  = TW'((4'd1 << job.g) - 4'd1);

    case (job.axis)
      AXIS_X: begin
        c_n = COORD_W'(h_ax_r);
        c_u = COORD_W'(h_ay_r);
        c_v = COORD_W'(h_az_r);
      end
      AXIS_Y: begin
        c_n = COORD_W'(h_ay_r);
        c_u = COORD_W'(h_ax_r);
        c_v = COORD_W'(h_az_r);
      end
      default: begin
        c_n = COORD_W'(h_az_r);
        c_u = COORD_W'(h_ax_r);
        c_v = COORD_W'(h_ay_r);
      end
    endcase

    // Odd faces look toward +axis: step a full cell; even faces step back dh.
    job.cn = h_face_r[0] ? (c_n + size_c) : (c_n - dh);

    if (!h_nb_r) begin
      // Half-size cells come out in fixed order from the anchor itself.
      job.ua = c_u;
      job.va = c_v;
    end else begin
      // Align to the cell grid but keep the bits below the fine cell size.
      job.ua = (c_u & ~smask) | (c_u & dmask);
      job.va = (c_v & ~smask) | (c_v & dmask);
      if (!size22[COORD_W]) begin
        job.off_u = TW'(c_u >> job.k) & gmask;
        job.off_v = TW'(c_v >> job.k) & gmask;
      end
    end
    job.ub = job.ua + size_c;
    job.vb = job.va + size_c;

    // Block B lies below block A when the step wraps around the domain.
    job.swap_u  = (job.off_u != '0) && (job.ub < job.ua);
    job.swap_v  = (job.off_v != '0) && (job.vb < job.va);
    job.v_major = (job.ua ^ job.ub) <= (job.va ^ job.vb);

    if (job.kind == JOB_KEYS) begin
      for (int j = 0; j < 4; j++) begin
        sel = blk_sel(2'(j), job.v_major, job.swap_u, job.swap_v);
        job.blk_mask[j] = (!sel[0] || (job.off_u != '0)) &&
                          (!sel[1] || (job.off_v != '0));
      end
    end else begin
      sel = '0;
    end
  end

endmodule

`default_nettype wire

// ===== design/fnmk_queue.sv =====
`default_nettype none

module fnmk_queue import fnmk_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic push_ready,
  output logic pop_valid,
  output job_t pop_job,
  input  logic pop
);

  job_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_CNT_W-1:0] cnt_r;
  logic               do_push;
  logic               do_pop;

  assign push_ready = cnt_r != Q_CNT_W'(Q_DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_job    = mem_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + Q_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - Q_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

// ===== design/fnmk_back.sv =====
`default_nettype none
`include "face_neighbour_morton_keys_assert.svh"

module fnmk_back import fnmk_pkg::*; #(
  parameter int unsigned MAX_GAP = 3
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  job_t       q_job,
  output logic       q_pop,
  fnmk_out_if.source out_if
);

  // Scan counter covers a full 2^g by 2^g block; balanced mode needs g = 1.
  localparam int unsigned DW = (2 * MAX_GAP < 2) ? 2 : 2 * MAX_GAP;

  job_t             job_r;
  logic             busy_r;
  logic             busy_nxt;
  logic [1:0]       j_r;
  logic [1:0]       j_nxt;
  logic [DW-1:0]    d_r;
  logic [DW-1:0]    d_nxt;
  logic [DW-1:0]    cnt_r;
  logic [DW-1:0]    cnt_nxt;
  logic             ov_r;
  logic             ov_nxt;
  logic [KEY_W-1:0] key_r;
  logic [KEY_W-1:0] key_nxt;
  logic             last_r;
  logic             last_nxt;
  logic             emp_r;
  logic             emp_nxt;
  logic             err_r;
  logic             err_nxt;

  logic [2*TW-1:0]    d_ext;
  logic [TW-1:0]      tu;
  logic [TW-1:0]      tv;
  logic [1:0]         sel;
  logic               mem_u;
  logic               mem_v;
  logic [COORD_W-1:0] cu;
  logic [COORD_W-1:0] cv;
  logic [COORD_W-1:0] cx;
  logic [COORD_W-1:0] cy;
  logic [COORD_W-1:0] cz;
  logic [DW-1:0]      dmax;
  logic [1:0]         nb;
  logic               slot_free;
  logic               finish;

  assign out_if.valid      = ov_r;
  assign out_if.morton_key = key_r;
  assign out_if.last       = last_r;
  assign out_if.empty_res  = emp_r;
  assign out_if.gap_error  = err_r;

  assign slot_free = !ov_r || out_if.ready;

  // Candidate cell for the current scan position.
  always_comb begin
    d_ext = (2*TW)'(d_r);
    for (int i = 0; i < TW; i++) begin
      tu[i] = d_ext[2*i];
      tv[i] = d_ext[2*i + 1];
    end
    sel   = blk_sel(j_r, job_r.v_major, job_r.swap_u, job_r.swap_v);
    mem_u = sel[0] ? (tu < job_r.off_u) : (tu >= job_r.off_u);
    mem_v = sel[1] ? (tv < job_r.off_v) : (tv >= job_r.off_v);
    cu    = (sel[0] ? job_r.ub : job_r.ua) + (COORD_W'(tu) << job_r.k);
    cv    = (sel[1] ? job_r.vb : job_r.va) + (COORD_W'(tv) << job_r.k);
    case (job_r.axis)
      AXIS_X: begin
        cx = job_r.cn;
        cy = cu;
        cz = cv;
      end
      AXIS_Y: begin
        cx = cu;
        cy = job_r.cn;
        cz = cv;
      end
      default: begin
        cx = cu;
        cy = cv;
        cz = job_r.cn;
      end
    endcase
    dmax = DW'((7'd1 << {job_r.g, 1'b0}) - 7'd1);
    nb   = j_r;
    for (int i = 3; i >= 1; i--) begin
      if ((2'(i) > j_r) && job_r.blk_mask[i]) begin
        nb = 2'(i);
      end
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    j_nxt    = j_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    ov_nxt   = ov_r;
    key_nxt  = key_r;
    last_nxt = last_r;
    emp_nxt  = emp_r;
    err_nxt  = err_r;
    finish   = 1'b0;

    if (slot_free) begin
      ov_nxt = 1'b0;
    end

    if (busy_r && slot_free) begin
      if (job_r.kind != JOB_KEYS) begin
        // Single flagged result, key zero.
        ov_nxt   = 1'b1;
        key_nxt  = '0;
        last_nxt = 1'b1;
        emp_nxt  = job_r.kind == JOB_EMPTY;
        err_nxt  = job_r.kind == JOB_ERROR;
        finish   = 1'b1;
      end else begin
        if (mem_u && mem_v) begin
          ov_nxt   = 1'b1;
          key_nxt  = interleave3(cx, cy, cz);
          last_nxt = cnt_r == dmax;
          emp_nxt  = 1'b0;
          err_nxt  = 1'b0;
          cnt_nxt  = cnt_r + DW'(1);
          finish   = cnt_r == dmax;
        end
        // Advance the scan, hopping to the next live block at block end.
        if (d_r == dmax) begin
          d_nxt = '0;
          j_nxt = nb;
        end else begin
          d_nxt = d_r + DW'(1);
        end
      end
    end

    if (finish) begin
      busy_nxt = 1'b0;
    end

    q_pop = q_valid && (!busy_r || finish);
    if (q_pop) begin
      busy_nxt = 1'b1;
      j_nxt    = '0;
      d_nxt    = '0;
      cnt_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    j_r    <= j_nxt;
    d_r    <= d_nxt;
    cnt_r  <= cnt_nxt;
    key_r  <= key_nxt;
    last_r <= last_nxt;
    emp_r  <= emp_nxt;
    err_r  <= err_nxt;
    if (q_pop) begin
      job_r <= q_job;
    end
  end

  `FNMK_ASSERT_IMP(a_flag_single, clk, rst_n, ov_r && (emp_r || err_r), last_r && (key_r == '0))
  `FNMK_ASSERT_IMP(a_cnt_range, clk, rst_n, busy_r && (job_r.kind == JOB_KEYS), cnt_r <= dmax)
  `FNMK_ASSERT_IMP(a_blk_live, clk, rst_n, busy_r && (job_r.kind == JOB_KEYS), job_r.blk_mask[j_r])
  `FNMK_ASSERT_NXT(a_finish_idle, clk, rst_n, finish && !q_valid, !busy_r)

endmodule

`default_nettype wire
